// ----- hdl/imhq_pkg.sv -----
// Package for the indexed min-heap queue: widths, operation and status codes.
// No dependencies.
package imhq_pkg;
    localparam int CAPACITY_DEF = 256;
    localparam int ID_WIDTH_DEF = 10;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int PAYLOAD_WIDTH_DEF = 32;
    localparam int OP_WIDTH = 2;
    localparam int STATUS_WIDTH = 3;
    localparam int LIMIT_WIDTH = 9;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 9'd256;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_INSERT = 2'd0,
        OP_SET_KEY = 2'd1,
        OP_REMOVE = 2'd2,
        OP_DELETE_MIN = 2'd3
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK = 3'd0,
        ST_FULL = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;
endpackage

// ----- hdl/imhq_heap_ram.sv -----
// Heap entry memory: key, id and payload per position, one write and one read port.
// Depends on imhq_pkg.
module imhq_heap_ram import imhq_pkg::*; #(
    parameter int DEPTH = CAPACITY_DEF + 1,
    parameter int AW = 9,
    parameter int W = 74
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/imhq_pos_ram.sv -----
// Position map memory: heap position per id, cleared by a sweep after reset.
// Depends on imhq_pkg.
module imhq_pos_ram import imhq_pkg::*; #(
    parameter int IW = ID_WIDTH_DEF,
    parameter int PW = 9
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [PW-1:0] wdata,
    input  logic [IW-1:0] raddr,
    output logic [PW-1:0] rdata
);
    logic [PW-1:0] mem [2**IW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/indexed_min_heap_queue.sv -----
// Top level of the indexed min-heap queue: sequencer, heap memory and position map.
// Depends on imhq_pkg, imhq_heap_ram and imhq_pos_ram.
// Each word is looked up in the position map and its entry fetched, then sifted up or
// down and written back; an error status, or removing the last entry, goes straight to
// the output. The pace of a sift is set by the single read port of the heap memory.
// One word at a time: the next word is taken in the cycle after the result is accepted.
// After reset a sweep clears all 2**ID_WIDTH entries of the position map (1024 by default).
module indexed_min_heap_queue import imhq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_wen,
    input  logic [LIMIT_WIDTH-1:0] cfg_wdata,
    input  logic s_tvalid,
    output logic s_tready,
    // operation, id, key, payload
    input  logic [((OP_WIDTH+ID_WIDTH+KEY_WIDTH+PAYLOAD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // status, out_id, out_key, out_payload
    output logic [((STATUS_WIDTH+ID_WIDTH+KEY_WIDTH+PAYLOAD_WIDTH+7)/8)*8-1:0] m_tdata
);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_WIDTH + ID_WIDTH + PAYLOAD_WIDTH;
    localparam int ID_COUNT = 2 ** ID_WIDTH;
    localparam int OW = ((STATUS_WIDTH+ID_WIDTH+KEY_WIDTH+PAYLOAD_WIDTH+7)/8)*8;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_LOOK_W, S_DISPATCH, S_ROOT_W,
        S_LAST_W, S_PLACE, S_UP_RD, S_UP_W, S_DN_L, S_DN_LRD, S_DN_LW, S_DN_RW,
        S_DN_CW, S_DN_DEC, S_FINISH, S_OUT
    } state_t;

    state_t state_reg;
    logic [LIMIT_WIDTH-1:0] limit_reg;
    logic [PW-1:0] count_reg, pos_reg, hpos_reg;
    logic [ID_WIDTH-1:0] clr_reg;
    logic clr_done_reg;
    op_t op_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    // entry being sifted
    logic [KEY_WIDTH-1:0] sk_reg;
    logic [ID_WIDTH-1:0] sid_reg;
    logic [PAYLOAD_WIDTH-1:0] spl_reg;
    logic [EW-1:0] left_reg;
    logic [STATUS_WIDTH-1:0] st_reg;
    logic [ID_WIDTH-1:0] oid_reg;
    logic [KEY_WIDTH-1:0] okey_reg;
    logic [PAYLOAD_WIDTH-1:0] opl_reg;

    logic h_we, p_we;
    logic [PW-1:0] h_waddr, h_raddr, p_wdata, p_rdata;
    logic [EW-1:0] h_wdata, h_rdata;
    logic [ID_WIDTH-1:0] p_waddr, p_raddr;

    imhq_heap_ram #(.DEPTH(CAPACITY + 1), .AW(PW), .W(EW)) u_heap (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );
    imhq_pos_ram #(.IW(ID_WIDTH), .PW(PW)) u_pos (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    logic [KEY_WIDTH-1:0] r_key;
    logic [ID_WIDTH-1:0] r_id;
    logic [PAYLOAD_WIDTH-1:0] r_pl;
    assign r_key = h_rdata[EW-1 -: KEY_WIDTH];
    assign r_id = h_rdata[PAYLOAD_WIDTH +: ID_WIDTH];
    assign r_pl = h_rdata[PAYLOAD_WIDTH-1:0];

    function automatic logic key_lt(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    logic [PW:0] lim_eff;
    logic present;
    logic [PW:0] lchild;
    assign lim_eff = ({{(PW+1){1'b0}}, limit_reg} < (PW+1+LIMIT_WIDTH)'(CAPACITY)) ?
                     (PW+1)'(limit_reg) : (PW+1)'(CAPACITY);
    assign present = (p_rdata != '0) && (p_rdata <= count_reg);
    assign lchild = {pos_reg, 1'b0};

    // memory port control driven by the sequencer
    always_comb begin
        h_we = 1'b0;
        h_waddr = pos_reg;
        h_wdata = {sk_reg, sid_reg, spl_reg};
        h_raddr = hpos_reg;
        p_we = 1'b0;
        p_waddr = sid_reg;
        p_wdata = pos_reg;
        p_raddr = id_reg;
        case (state_reg)
            S_CLEAR: begin
                p_we = 1'b1;
                p_waddr = clr_reg;
                p_wdata = '0;
            end
            S_UP_W: begin
                if (pos_reg > 1 && key_lt(sk_reg, r_key)) begin
                    h_we = 1'b1;
                    h_wdata = h_rdata;
                    p_we = 1'b1;
                    p_waddr = r_id;
                end
            end
            S_DN_DEC: begin
                if (!key_lt(sk_reg, r_key)) begin
                    h_we = 1'b1;
                    h_wdata = h_rdata;
                    p_we = 1'b1;
                    p_waddr = r_id;
                end
            end
            S_FINISH: begin
                h_we = 1'b1;
                p_we = 1'b1;
            end
            S_OUT: begin
                p_we = (op_reg == OP_REMOVE || op_reg == OP_DELETE_MIN)
                       && st_reg == ST_OK && !m_tvalid;
                p_waddr = (op_reg == OP_REMOVE) ? id_reg : oid_reg;
                p_wdata = '0;
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tdata = OW'({opl_reg, okey_reg, oid_reg, st_reg}) >> 0;

    logic m_valid_reg;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            limit_reg <= LIMIT_RESET;
            count_reg <= '0;
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ID_WIDTH'(ID_COUNT - 1)) begin
                        state_reg <= S_IDLE;
                        clr_done_reg <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg <= op_t'(s_tdata[OP_WIDTH-1:0]);
                        id_reg <= s_tdata[OP_WIDTH +: ID_WIDTH];
                        key_reg <= s_tdata[OP_WIDTH+ID_WIDTH +: KEY_WIDTH];
                        pay_reg <= s_tdata[OP_WIDTH+ID_WIDTH+KEY_WIDTH +: PAYLOAD_WIDTH];
                        st_reg <= ST_OK;
                        oid_reg <= '0;
                        okey_reg <= '0;
                        opl_reg <= '0;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // position map read is in flight
                    state_reg <= S_LOOK_W;
                end
                S_LOOK_W: begin
                    case (op_reg)
                        OP_INSERT: begin
                            if ({1'b0, count_reg} >= lim_eff) begin
                                st_reg <= ST_FULL;
                                state_reg <= S_OUT;
                            end else if (present) begin
                                st_reg <= ST_DUPLICATE;
                                state_reg <= S_OUT;
                            end else begin
                                count_reg <= count_reg + 1'b1;
                                pos_reg <= count_reg + 1'b1;
                                sk_reg <= key_reg;
                                sid_reg <= id_reg;
                                spl_reg <= pay_reg;
                                hpos_reg <= (count_reg + 1'b1) >> 1;
                                state_reg <= S_UP_RD;
                            end
                        end
                        OP_SET_KEY, OP_REMOVE: begin
                            if (!present) begin
                                st_reg <= ST_NOT_FOUND;
                                state_reg <= S_OUT;
                            end else begin
                                pos_reg <= p_rdata;
                                hpos_reg <= p_rdata;
                                state_reg <= S_DISPATCH;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                st_reg <= ST_EMPTY;
                                state_reg <= S_OUT;
                            end else begin
                                pos_reg <= PW'(1);
                                hpos_reg <= PW'(1);
                                state_reg <= S_DISPATCH;
                            end
                        end
                    endcase
                end
                S_DISPATCH: begin
                    state_reg <= S_ROOT_W;
                end
                S_ROOT_W: begin
                    // entry at pos_reg is now on the read port
                    if (op_reg == OP_SET_KEY) begin
                        sk_reg <= key_reg;
                        sid_reg <= r_id;
                        spl_reg <= r_pl;
                        if (key_lt(key_reg, r_key)) begin
                            hpos_reg <= pos_reg >> 1;
                            state_reg <= S_UP_RD;
                        end else if (key_lt(r_key, key_reg)) begin
                            state_reg <= S_DN_L;
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end else begin
                        oid_reg <= (op_reg == OP_DELETE_MIN) ? r_id : '0;
                        okey_reg <= r_key;
                        opl_reg <= r_pl;
                        sk_reg <= r_key;
                        count_reg <= count_reg - 1'b1;
                        if (pos_reg == count_reg) begin
                            state_reg <= S_OUT;
                        end else begin
                            hpos_reg <= count_reg;
                            state_reg <= S_LAST_W;
                        end
                    end
                end
                S_LAST_W: begin
                    state_reg <= S_PLACE;
                end
                S_PLACE: begin
                    // last entry fills the hole; sk_reg holds the removed key
                    sk_reg <= r_key;
                    sid_reg <= r_id;
                    spl_reg <= r_pl;
                    if (op_reg == OP_DELETE_MIN) begin
                        state_reg <= S_DN_L;
                    end else if (key_lt(r_key, sk_reg)) begin
                        hpos_reg <= pos_reg >> 1;
                        state_reg <= S_UP_RD;
                    end else if (key_lt(sk_reg, r_key)) begin
                        state_reg <= S_DN_L;
                    end else begin
                        state_reg <= S_FINISH;
                    end
                end
                S_UP_RD: begin
                    state_reg <= S_UP_W;
                end
                S_UP_W: begin
                    if (pos_reg > 1 && key_lt(sk_reg, r_key)) begin
                        pos_reg <= hpos_reg;
                        hpos_reg <= hpos_reg >> 1;
                        state_reg <= S_UP_RD;
                    end else begin
                        state_reg <= S_FINISH;
                    end
                end
                S_DN_L: begin
                    if (lchild > {1'b0, count_reg}) begin
                        state_reg <= S_FINISH;
                    end else begin
                        hpos_reg <= PW'(lchild);
                        state_reg <= S_DN_LRD;
                    end
                end
                S_DN_LRD: begin
                    // left child read is in flight
                    if (lchild != {1'b0, count_reg}) begin
                        hpos_reg <= PW'(lchild + 1'b1);
                    end
                    state_reg <= S_DN_LW;
                end
                S_DN_LW: begin
                    left_reg <= h_rdata;
                    if (lchild == {1'b0, count_reg}) begin
                        state_reg <= S_DN_DEC;
                    end else begin
                        state_reg <= S_DN_RW;
                    end
                end
                S_DN_RW: begin
                    // right child on the port; pick left only when strictly smaller
                    if (key_lt(left_reg[EW-1 -: KEY_WIDTH], r_key)) begin
                        hpos_reg <= PW'(lchild);
                        state_reg <= S_DN_CW;
                    end else begin
                        state_reg <= S_DN_DEC;
                    end
                end
                S_DN_CW: begin
                    state_reg <= S_DN_DEC;
                end
                S_DN_DEC: begin
                    if (!key_lt(sk_reg, r_key)) begin
                        pos_reg <= hpos_reg;
                        state_reg <= S_DN_L;
                    end else begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                    end else if (m_tready) begin
                        m_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input taken while a result is pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, count_reg} <= (PW+1)'(CAPACITY)))
        else $error("entry count above capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> clr_done_reg)
        else $error("input taken before position map cleared");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");
endmodule

// ----- dv/indexed_min_heap_queue_tb.sv -----
// Testbench for the indexed min-heap queue: directed and random heap operations
// checked word by word against a behavioral heap model kept in the testbench.
// Depends on imhq_pkg and the indexed_min_heap_queue RTL.
module indexed_min_heap_queue_tb;
    import imhq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = CAPACITY_DEF;
    localparam int IDW = ID_WIDTH_DEF;
    localparam int KW = KEY_WIDTH_DEF;
    localparam int PW = PAYLOAD_WIDTH_DEF;
    localparam int SW = ((OP_WIDTH + IDW + KW + PW + 7) / 8) * 8;
    localparam int MW = ((STATUS_WIDTH + IDW + KW + PW + 7) / 8) * 8;
    localparam int STALL_LIMIT = 20000;
    localparam int NUM_IDS = 1 << IDW;

    typedef struct packed {
        logic [PW-1:0] payload;
        logic signed [KW-1:0] key;
        logic [IDW-1:0] id;
        status_t status;
    } heap_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wen = 1'b0;
    logic [LIMIT_WIDTH-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MW-1:0] m_tdata;

    indexed_min_heap_queue dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Heap model.
    logic signed [KW-1:0] mdl_key [1:CAP];
    logic [IDW-1:0] mdl_id [1:CAP];
    logic [PW-1:0] mdl_pay [1:CAP];
    int mdl_pos [NUM_IDS];
    int mdl_count;
    int mdl_limit;

    heap_result_t expected_results [$];
    bit failed = 1'b0;
    bit quiet_sink = 1'b0;
    int idle_cycles = 0;

    function automatic void place(int p, logic signed [KW-1:0] k, logic [IDW-1:0] i,
            logic [PW-1:0] pl);
        mdl_key[p] = k;
        mdl_id[p] = i;
        mdl_pay[p] = pl;
        mdl_pos[i] = p;
    endfunction

    function automatic void bubble_up(int p);
        logic signed [KW-1:0] k;
        logic [IDW-1:0] i;
        logic [PW-1:0] pl;
        k = mdl_key[p];
        i = mdl_id[p];
        pl = mdl_pay[p];
        while (p > 1 && k < mdl_key[p / 2]) begin
            place(p, mdl_key[p / 2], mdl_id[p / 2], mdl_pay[p / 2]);
            p = p / 2;
        end
        place(p, k, i, pl);
    endfunction

    function automatic void bubble_down(int p);
        logic signed [KW-1:0] k;
        logic [IDW-1:0] i;
        logic [PW-1:0] pl;
        int c;
        k = mdl_key[p];
        i = mdl_id[p];
        pl = mdl_pay[p];
        while (2 * p <= mdl_count) begin
            c = 2 * p;
            if (c != mdl_count && !(mdl_key[c] < mdl_key[c + 1])) c = c + 1;
            if (mdl_key[c] > k) break;
            place(p, mdl_key[c], mdl_id[c], mdl_pay[c]);
            p = c;
        end
        place(p, k, i, pl);
    endfunction

    function automatic heap_result_t apply_op(op_t op, logic [IDW-1:0] id,
            logic signed [KW-1:0] key, logic [PW-1:0] pay);
        heap_result_t r;
        int p;
        int lim;
        bit present;
        logic signed [KW-1:0] old;
        r = '0;
        r.status = ST_OK;
        lim = mdl_limit < CAP ? mdl_limit : CAP;
        p = mdl_pos[id];
        present = p != 0 && p <= mdl_count;
        case (op)
            OP_INSERT: begin
                if (mdl_count >= lim) r.status = ST_FULL;
                else if (present) r.status = ST_DUPLICATE;
                else begin
                    mdl_count++;
                    place(mdl_count, key, id, pay);
                    bubble_up(mdl_count);
                end
            end
            OP_SET_KEY: begin
                if (!present) r.status = ST_NOT_FOUND;
                else begin
                    old = mdl_key[p];
                    mdl_key[p] = key;
                    if (old > key) bubble_up(p);
                    else if (key > old) bubble_down(p);
                end
            end
            OP_REMOVE: begin
                if (!present) r.status = ST_NOT_FOUND;
                else begin
                    r.key = mdl_key[p];
                    r.payload = mdl_pay[p];
                    mdl_pos[id] = 0;
                    mdl_count--;
                    if (p != mdl_count + 1) begin
                        place(p, mdl_key[mdl_count + 1], mdl_id[mdl_count + 1],
                            mdl_pay[mdl_count + 1]);
                        if (r.key > mdl_key[p]) bubble_up(p);
                        else if (mdl_key[p] > r.key) bubble_down(p);
                    end
                end
            end
            default: begin
                if (mdl_count == 0) r.status = ST_EMPTY;
                else begin
                    r.id = mdl_id[1];
                    r.key = mdl_key[1];
                    r.payload = mdl_pay[1];
                    mdl_pos[mdl_id[1]] = 0;
                    mdl_count--;
                    if (mdl_count != 0) begin
                        place(1, mdl_key[mdl_count + 1], mdl_id[mdl_count + 1],
                            mdl_pay[mdl_count + 1]);
                        bubble_down(1);
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_word(op_t op, logic [IDW-1:0] id, logic signed [KW-1:0] key,
            logic [PW-1:0] pay, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= SW'({pay, key, id, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(apply_op(op, id, key, pay));
    endtask

    task automatic drain(int extra);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_limit(int value);
        drain(40);
        cfg_wen <= 1'b1;
        cfg_wdata <= LIMIT_WIDTH'(value);
        @(posedge aclk);
        cfg_wen <= 1'b0;
        mdl_limit = value;
    endtask

    function automatic logic [IDW-1:0] present_id();
        if (mdl_count == 0) return IDW'($urandom);
        return mdl_id[$urandom_range(1, mdl_count)];
    endfunction

    function automatic logic signed [KW-1:0] rand_key();
        case ($urandom_range(0, 3))
            0: return KW'($signed($urandom_range(0, 15)) - 8);
            1: return {1'b1, {(KW - 1){1'b0}}};
            default: return KW'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_word(OP_DELETE_MIN, '0, '0, '0, 1'b0);
        send_word(OP_SET_KEY, '1, '0, '0, 1'b0);
        send_word(OP_REMOVE, '1, '0, '0, 1'b0);
        send_word(OP_INSERT, '1, {1'b0, {(KW - 1){1'b1}}}, '1, 1'b0);
        send_word(OP_INSERT, '0, {1'b1, {(KW - 1){1'b0}}}, '0, 1'b0);
        send_word(OP_INSERT, 10'd5, 32'sd7, 32'h55aa_33cc, 1'b0);
        send_word(OP_INSERT, 10'd6, 32'sd7, 32'hcc33_aa55, 1'b0);
        send_word(OP_INSERT, 10'd5, 32'sd1, 32'h0, 1'b0);
        send_word(OP_SET_KEY, 10'd5, 32'sd7, '0, 1'b0);
        send_word(OP_SET_KEY, 10'd6, -32'sd3, '0, 1'b0);
        send_word(OP_SET_KEY, '0, 32'sd100, '0, 1'b0);
        send_word(OP_INSERT, 10'd9, 32'sd7, 32'h1, 1'b0);
        send_word(OP_REMOVE, 10'd9, '0, '0, 1'b0);
        send_word(OP_REMOVE, 10'd5, '0, '0, 1'b0);
        send_word(OP_REMOVE, 10'd5, '0, '0, 1'b0);
        repeat (5) send_word(OP_DELETE_MIN, '0, '0, '0, 1'b0);
    endtask

    task automatic test_limits();
        write_limit(1);
        send_word(OP_INSERT, 10'd3, 32'sd1, 32'h3, 1'b0);
        send_word(OP_INSERT, 10'd4, 32'sd2, 32'h4, 1'b0);
        send_word(OP_INSERT, 10'd3, 32'sd2, 32'h4, 1'b0);
        send_word(OP_DELETE_MIN, '0, '0, '0, 1'b0);
        write_limit(0);
        send_word(OP_INSERT, 10'd3, 32'sd1, 32'h3, 1'b0);
        write_limit(511);
        while (mdl_count < CAP) send_word(OP_INSERT, IDW'($urandom), rand_key(), $urandom, 1'b1);
        send_word(OP_INSERT, present_id(), rand_key(), $urandom, 1'b0);
        repeat (40) send_word(OP_SET_KEY, present_id(), rand_key(), '0, 1'b1);
        repeat (40) send_word(OP_REMOVE, present_id(), '0, '0, 1'b1);
        while (mdl_count > 0) send_word(OP_DELETE_MIN, '0, '0, '0, 1'b1);
    endtask

    task automatic test_random(int n, bit gaps);
        op_t op;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40 - (mdl_count > mdl_limit / 2 ? 15 : 0)) op = OP_INSERT;
            else if (sel < 60) op = OP_SET_KEY;
            else if (sel < 78) op = OP_REMOVE;
            else op = OP_DELETE_MIN;
            send_word(op, ($urandom_range(0, 4) != 0 && op != OP_INSERT) ? present_id()
                : IDW'($urandom), rand_key(), $urandom, gaps);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn || quiet_sink) m_tready <= 1'b1;
        else if (m_tready && $urandom_range(0, 5) == 0) m_tready <= 1'b0;
        else if (!m_tready && $urandom_range(0, 2) == 0) m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        heap_result_t got;
        heap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = heap_result_t'(m_tdata[STATUS_WIDTH + IDW + KW + PW - 1:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, got);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.id !== want.id
                        || got.key !== want.key || got.payload !== want.payload) begin
                    $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_IDS; i++) mdl_pos[i] = 0;
        mdl_count = 0;
        mdl_limit = 256;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_limits();
        write_limit(17);
        test_random(150, 1'b1);
        write_limit(256);
        test_random(250, 1'b1);
        drain(0);
        test_random(150, 1'b1);
        quiet_sink = 1'b1;
        test_random(100, 1'b0);
        drain(40);
        if (!failed) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/imhq_pkg.sv
hdl/imhq_heap_ram.sv
hdl/imhq_pos_ram.sv
hdl/indexed_min_heap_queue.sv
dv/indexed_min_heap_queue_tb.sv
